[sv/readable_text_classifier_defines.svh]
// ----------------------------------------------------------------------------
// readable_text_classifier_defines
// assertion macros used by rtc_tally
// ----------------------------------------------------------------------------
`ifndef READABLE_TEXT_CLASSIFIER_DEFINES_SVH
`define READABLE_TEXT_CLASSIFIER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define RTC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define RTC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/rtc_pkg.sv]
// ----------------------------------------------------------------------------
// rtc_pkg
// types, register map and verdict codes of the readable text classifier
// ----------------------------------------------------------------------------
package rtc_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int PROD_WIDTH  = COUNT_WIDTH + 4;
  localparam int ADDR_WIDTH  = 4;
  localparam int DATA_WIDTH  = 32;

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [PROD_WIDTH-1:0]  prod_t;
  typedef logic [3:0]             tenths_t;
  typedef logic [7:0]             run_t;
  typedef logic [2:0]             code_t;
  typedef logic [1:0]             reg_idx_t;

  localparam cnt_t CNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam run_t RUN_MAX = 8'hFF;

  localparam code_t CODE_READABLE = 3'd0;
  localparam code_t CODE_EMPTY    = 3'd1;
  localparam code_t CODE_CONTROL  = 3'd2;
  localparam code_t CODE_RATIO    = 3'd3;
  localparam code_t CODE_OVERFLOW = 3'd4;

  localparam reg_idx_t REG_MIN_PRINTABLE = 2'd0;
  localparam reg_idx_t REG_MIN_ALPHA     = 2'd1;
  localparam reg_idx_t REG_MAX_DIGIT     = 2'd2;
  localparam reg_idx_t REG_MAX_RUN       = 2'd3;

  localparam tenths_t RST_MIN_PRINTABLE = 4'd9;
  localparam tenths_t RST_MIN_ALPHA     = 4'd1;
  localparam tenths_t RST_MAX_DIGIT     = 4'd5;
  localparam run_t    RST_MAX_RUN       = 8'd2;

  typedef struct packed {
    tenths_t min_printable_tenths;
    tenths_t min_alpha_tenths;
    tenths_t max_digit_tenths;
    run_t    max_control_run;
  } cfg_t;

  typedef struct packed {
    logic  readable;
    code_t verdict_code;
  } verdict_t;

endpackage

[sv/rtc_if.sv]
// ----------------------------------------------------------------------------
// rtc_if
// valid/ready channels for string bytes and verdicts
// ----------------------------------------------------------------------------
interface rtc_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink   (input valid, input char_byte, output ready);
endinterface

interface rtc_verdict_if;
  import rtc_pkg::*;
  logic  valid;
  logic  ready;
  logic  readable;
  code_t verdict_code;

  modport source (output valid, output readable, output verdict_code, input ready);
  modport sink   (input valid, input readable, input verdict_code, output ready);
endinterface

[sv/rtc_tally.sv]
// ----------------------------------------------------------------------------
// rtc_tally
// per-string counters and end-of-string judgement
// ----------------------------------------------------------------------------
`include "readable_text_classifier_defines.svh"

module rtc_tally (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        char_byte,
  input  rtc_pkg::cfg_t     cfg,
  output rtc_pkg::verdict_t verdict
);
  import rtc_pkg::*;

  cnt_t length_count, length_count_next;
  cnt_t print_count, print_count_next;
  cnt_t letter_count, letter_count_next;
  cnt_t numeral_count, numeral_count_next;
  logic space_seen, space_seen_next;
  run_t control_run, control_run_next;
  logic run_rejected, run_rejected_next;
  logic length_overflow, length_overflow_next;

  logic  is_end, is_high, is_print, is_alpha, is_digit, is_space;
  run_t  run_inc;
  prod_t printable_x10, alpha_x10, digit_x10;
  prod_t printable_lim, alpha_lim, digit_lim;
  logic  shares_ok;

  assign is_end   = (char_byte == 8'h00);
  assign is_high  = char_byte[7];
  assign is_print = (char_byte >= 8'h20) && (char_byte <= 8'h7E);
  assign is_alpha = ((char_byte >= 8'h41) && (char_byte <= 8'h5A)) ||
                    ((char_byte >= 8'h61) && (char_byte <= 8'h7A));
  assign is_digit = (char_byte >= 8'h30) && (char_byte <= 8'h39);
  assign is_space = (char_byte == 8'h20);
  assign run_inc  = (control_run == RUN_MAX) ? control_run : control_run + 8'd1;

  always_comb begin
    length_count_next    = length_count;
    print_count_next     = print_count;
    letter_count_next    = letter_count;
    numeral_count_next   = numeral_count;
    space_seen_next      = space_seen;
    control_run_next     = control_run;
    run_rejected_next    = run_rejected;
    length_overflow_next = length_overflow;
    if (step) begin
      if (is_end) begin
        length_count_next    = '0;
        print_count_next     = '0;
        letter_count_next    = '0;
        numeral_count_next   = '0;
        space_seen_next      = 1'b0;
        control_run_next     = '0;
        run_rejected_next    = 1'b0;
        length_overflow_next = 1'b0;
      end else if (length_count == CNT_MAX) begin
        length_overflow_next = 1'b1;
      end else begin
        length_count_next = length_count + cnt_t'(1);
        if (!is_high) begin
          if (is_print) begin
            print_count_next = print_count + cnt_t'(1);
            control_run_next = '0;
            if (is_alpha) begin
              letter_count_next = letter_count + cnt_t'(1);
            end else if (is_digit) begin
              numeral_count_next = numeral_count + cnt_t'(1);
            end else if (is_space) begin
              space_seen_next = 1'b1;
            end
          end else begin
            control_run_next = run_inc;
            if (run_inc > cfg.max_control_run) begin
              run_rejected_next = 1'b1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length_count    <= '0;
      print_count     <= '0;
      letter_count    <= '0;
      numeral_count   <= '0;
      space_seen      <= 1'b0;
      control_run     <= '0;
      run_rejected    <= 1'b0;
      length_overflow <= 1'b0;
    end else begin
      length_count    <= length_count_next;
      print_count     <= print_count_next;
      letter_count    <= letter_count_next;
      numeral_count   <= numeral_count_next;
      space_seen      <= space_seen_next;
      control_run     <= control_run_next;
      run_rejected    <= run_rejected_next;
      length_overflow <= length_overflow_next;
    end
  end

  // share tests as count*10 against tenths*length
  assign printable_x10 = (prod_t'(print_count) << 3) + (prod_t'(print_count) << 1);
  assign alpha_x10     = (prod_t'(letter_count) << 3) + (prod_t'(letter_count) << 1);
  assign digit_x10     = (prod_t'(numeral_count) << 3) + (prod_t'(numeral_count) << 1);
  assign printable_lim = prod_t'(cfg.min_printable_tenths) * prod_t'(length_count);
  assign alpha_lim     = prod_t'(cfg.min_alpha_tenths) * prod_t'(length_count);
  assign digit_lim     = prod_t'(cfg.max_digit_tenths) * prod_t'(length_count);

  assign shares_ok = (printable_x10 > printable_lim) && (alpha_x10 > alpha_lim) &&
                     (digit_x10 < digit_lim) && space_seen;

  always_comb begin
    priority if (length_count == '0) begin
      verdict.verdict_code = CODE_EMPTY;
    end else if (run_rejected) begin
      verdict.verdict_code = CODE_CONTROL;
    end else if (length_overflow) begin
      verdict.verdict_code = CODE_OVERFLOW;
    end else if (shares_ok) begin
      verdict.verdict_code = CODE_READABLE;
    end else begin
      verdict.verdict_code = CODE_RATIO;
    end
    verdict.readable = (verdict.verdict_code == CODE_READABLE);
  end

  `RTC_ASSERT_NXT(a_clear_after_end, step && is_end,
                  (length_count == '0) && !run_rejected && !length_overflow && !space_seen,
                  "counters not cleared after string end")
  `RTC_ASSERT_IMP(a_overflow_at_max, length_overflow, length_count == CNT_MAX,
                  "overflow flag without full length count")
  `RTC_ASSERT_IMP(a_printable_le_length, 1'b1, print_count <= length_count,
                  "printable count exceeds length")
  `RTC_ASSERT_IMP(a_classes_le_printable, 1'b1,
                  ({1'b0, letter_count} + {1'b0, numeral_count}) <= {1'b0, print_count},
                  "alpha plus digit count exceeds printable count")

endmodule

[sv/readable_text_classifier.sv]
// ----------------------------------------------------------------------------
// readable_text_classifier
// byte-stream readability classifier with apb register port
// ----------------------------------------------------------------------------
// Takes one string byte per transaction on chars; a zero byte ends the string
// and produces one verdict transaction on verdicts (readable flag and code:
// 0 readable, 1 empty, 2 control run, 3 share or space fail, 4 overflow).
// Throughput is one byte per clock while the input side does not stall: each
// byte lands in an input register and then updates the counters, while the
// verdict of a zero byte is loaded into an output register when that byte
// leaves the input register, and is offered on verdicts from there.
// The input side stalls only when a verdict is ready to be written and the
// previous one is still waiting. Registers at byte addresses 0, 4, 8, 12:
// min_printable_tenths (reset 9), min_alpha_tenths (1), max_digit_tenths (5),
// max_control_run (2); write them only while no string is in flight.
// ----------------------------------------------------------------------------
module readable_text_classifier (
  input  logic                           clk,
  input  logic                           rst,
  rtc_char_if.sink                       chars,
  rtc_verdict_if.source                  verdicts,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rtc_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [rtc_pkg::DATA_WIDTH-1:0] pwdata,
  output logic [rtc_pkg::DATA_WIDTH-1:0] prdata,
  output logic                           pready
);
  import rtc_pkg::*;

  cfg_t       cfg;
  reg_idx_t   reg_idx;
  logic       cfg_write;

  logic       in_full;
  logic [7:0] in_byte;
  logic       advance;
  logic       out_valid;
  verdict_t   out_data;
  verdict_t   verdict;

  // register port
  assign pready    = 1'b1;
  assign reg_idx   = paddr[3:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_printable_tenths <= RST_MIN_PRINTABLE;
      cfg.min_alpha_tenths     <= RST_MIN_ALPHA;
      cfg.max_digit_tenths     <= RST_MAX_DIGIT;
      cfg.max_control_run      <= RST_MAX_RUN;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_MIN_PRINTABLE: cfg.min_printable_tenths <= pwdata[3:0];
        REG_MIN_ALPHA:     cfg.min_alpha_tenths     <= pwdata[3:0];
        REG_MAX_DIGIT:     cfg.max_digit_tenths     <= pwdata[3:0];
        REG_MAX_RUN:       cfg.max_control_run      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MIN_PRINTABLE: prdata = DATA_WIDTH'(cfg.min_printable_tenths);
      REG_MIN_ALPHA:     prdata = DATA_WIDTH'(cfg.min_alpha_tenths);
      REG_MAX_DIGIT:     prdata = DATA_WIDTH'(cfg.max_digit_tenths);
      REG_MAX_RUN:       prdata = DATA_WIDTH'(cfg.max_control_run);
      default:           prdata = '0;
    endcase
  end

  // input register
  assign advance     = in_full && ((in_byte != 8'h00) || !out_valid || verdicts.ready);
  assign chars.ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (chars.ready) begin
      in_full <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.valid && chars.ready) begin
      in_byte <= chars.char_byte;
    end
  end

  rtc_tally u_tally (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .char_byte (in_byte),
    .cfg       (cfg),
    .verdict   (verdict)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && (in_byte == 8'h00)) begin
      out_valid <= 1'b1;
    end else if (verdicts.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && (in_byte == 8'h00)) begin
      out_data <= verdict;
    end
  end

  assign verdicts.valid        = out_valid;
  assign verdicts.readable     = out_data.readable;
  assign verdicts.verdict_code = out_data.verdict_code;

endmodule

[sim/tb_readable_text_classifier.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_readable_text_classifier
// self-checking bench for the readable text classifier
// ----------------------------------------------------------------------------
// Feeds zero-terminated byte strings through the chars channel and checks
// every verdict against an in-bench tally of length, printable, alphabetic and
// digit bytes, control runs and overflow. A few hand-picked strings come
// first, then random strings under several register settings written over
// apb. Both channels idle at random, and the verdict side holds off once for
// a long stretch so that the block backs up into its input.
// ----------------------------------------------------------------------------
module tb_readable_text_classifier;
  import rtc_pkg::*;

  localparam int QUIET_LIMIT = 4000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [ADDR_WIDTH-1:0] paddr   = '0;
  logic [DATA_WIDTH-1:0] pwdata  = '0;
  logic [DATA_WIDTH-1:0] prdata;
  logic                  pready;

  rtc_char_if    chars_if ();
  rtc_verdict_if verdicts_if ();

  readable_text_classifier uut (
    .clk      (clk),
    .rst      (rst),
    .chars    (chars_if),
    .verdicts (verdicts_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // register shadow and running tally of the current string
  cfg_t cfg;
  cnt_t len_cnt, prn_cnt, alpha_cnt, digit_cnt;
  logic space_seen, run_rej, len_ovf;
  run_t ctl_run;

  logic [7:0] chars_pending[$];
  verdict_t   verdicts_due[$];

  int   mismatches    = 0;
  int   verdicts_taken = 0;
  int   backlog       = 0;
  int   gap_left      = 0;
  int   stall_left    = 0;
  int   hold_left     = 0;
  logic held_once     = 1'b0;
  logic calm          = 1'b0;

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 70) return 0;
    if (r < 97) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] pick_byte(input int mix);
    int r, ctl_pct, dig_pct, c;
    r = $urandom_range(0, 99);
    ctl_pct = (mix == 3) ? 35 : 3;
    dig_pct = (mix == 2) ? 45 : 6;
    if (mix == 1) return 8'($urandom_range(1, 255));
    if (r < ctl_pct) begin
      c = $urandom_range(0, 31);
      return (c == 0) ? 8'h7F : 8'(c);
    end
    r -= ctl_pct;
    if (r < 2) return 8'($urandom_range(8'h80, 8'hFF));
    r -= 2;
    if (r < dig_pct) return 8'(8'h30 + $urandom_range(0, 9));
    r -= dig_pct;
    if (r < 14) return 8'h20;
    r -= 14;
    if (r < 6) return 8'($urandom_range(8'h21, 8'h7E));
    c = $urandom_range(0, 51);
    return (c < 26) ? 8'(8'h41 + c) : 8'(8'h61 + c - 26);
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatches < 100) $display("mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) chars_pending.push_back(s[i]);
    chars_pending.push_back(8'h00);
  endtask

  task automatic push_random_string(output int len);
    int r, mix;
    r = $urandom_range(0, 99);
    mix = $urandom_range(0, 3);
    if (r < 8) len = 0;
    else if (r < 88) len = $urandom_range(1, 24);
    else if (r < 97) len = $urandom_range(25, 120);
    else len = $urandom_range(121, 400);
    repeat (len) chars_pending.push_back(pick_byte(mix));
    chars_pending.push_back(8'h00);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (chars_pending.size() != 0 || chars_if.valid || verdicts_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input reg_idx_t idx, input logic [31:0] value);
    logic [31:0] keep, word;
    keep = (idx == REG_MAX_RUN) ? 32'hFF : 32'hF;
    word = ($urandom() & ~keep) | (value & keep);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_MIN_PRINTABLE: cfg.min_printable_tenths = word[3:0];
      REG_MIN_ALPHA:     cfg.min_alpha_tenths     = word[3:0];
      REG_MAX_DIGIT:     cfg.max_digit_tenths     = word[3:0];
      REG_MAX_RUN:       cfg.max_control_run      = word[7:0];
      default: ;
    endcase
  endtask

  task automatic run_phase(input tenths_t p, input tenths_t a, input tenths_t d,
                           input run_t r, input int n);
    int pushed, len;
    pushed = 0;
    wait_idle();
    apb_write(REG_MIN_PRINTABLE, 32'(p));
    apb_write(REG_MIN_ALPHA, 32'(a));
    apb_write(REG_MAX_DIGIT, 32'(d));
    apb_write(REG_MAX_RUN, 32'(r));
    @(negedge clk);
    while (pushed < n) begin
      push_random_string(len);
      pushed += len + 1;
    end
  endtask

  // byte source
  always @(posedge clk) begin
    if (rst) begin
      chars_if.valid     <= 1'b0;
      chars_if.char_byte <= 8'h00;
      gap_left           <= 0;
    end else if (!chars_if.valid || chars_if.ready) begin
      if (gap_left != 0 || chars_pending.size() == 0) begin
        chars_if.valid <= 1'b0;
        if (gap_left != 0) gap_left <= gap_left - 1;
      end else begin
        chars_if.valid     <= 1'b1;
        chars_if.char_byte <= chars_pending.pop_front();
        gap_left           <= draw_gap();
      end
    end
    backlog <= chars_pending.size();
  end

  // verdict sink, with one long hold-off once traffic is flowing
  always @(posedge clk) begin
    if (rst) begin
      verdicts_if.ready <= 1'b0;
      stall_left        <= 0;
      hold_left         <= 0;
    end else if (!held_once && verdicts_taken >= 40 && backlog > 100) begin
      verdicts_if.ready <= 1'b0;
      hold_left         <= 500;
      held_once         <= 1'b1;
    end else if (hold_left != 0) begin
      verdicts_if.ready <= 1'b0;
      hold_left         <= hold_left - 1;
    end else if (stall_left != 0) begin
      verdicts_if.ready <= 1'b0;
      stall_left        <= stall_left - 1;
    end else begin
      verdicts_if.ready <= 1'b1;
      stall_left        <= ($urandom_range(0, 2) == 0) ? draw_gap() : 0;
    end
  end

  always @(posedge clk) begin
    if ($urandom_range(0, 299) == 0) calm <= ~calm;
  end

  // tally each accepted byte and predict the verdict on the terminator
  always @(posedge clk) begin : tally_chars
    logic [7:0]      b;
    longint unsigned n;
    code_t           code;
    verdict_t        v;
    b = chars_if.char_byte;
    n = len_cnt;
    if (!rst && chars_if.valid && chars_if.ready) begin
      if (b == 8'h00) begin
        if (len_cnt == '0) code = CODE_EMPTY;
        else if (run_rej) code = CODE_CONTROL;
        else if (len_ovf) code = CODE_OVERFLOW;
        else if (prn_cnt * 64'd10 > cfg.min_printable_tenths * n &&
                 alpha_cnt * 64'd10 > cfg.min_alpha_tenths * n &&
                 digit_cnt * 64'd10 < cfg.max_digit_tenths * n && space_seen) begin
          code = CODE_READABLE;
        end else code = CODE_RATIO;
        v.readable     = (code == CODE_READABLE);
        v.verdict_code = code;
        verdicts_due.push_back(v);
      end else if (len_cnt == CNT_MAX) begin
        len_ovf = 1'b1;
      end else begin
        len_cnt = len_cnt + 1'b1;
        if (b < 8'h80) begin
          if (b >= 8'h20 && b <= 8'h7E) begin
            prn_cnt = prn_cnt + 1'b1;
            ctl_run = '0;
            if ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")) alpha_cnt = alpha_cnt + 1'b1;
            else if (b >= "0" && b <= "9") digit_cnt = digit_cnt + 1'b1;
            else if (b == 8'h20) space_seen = 1'b1;
          end else begin
            if (ctl_run != RUN_MAX) ctl_run = ctl_run + 1'b1;
            if (ctl_run > cfg.max_control_run) run_rej = 1'b1;
          end
        end
      end
    end
    if (rst || (chars_if.valid && chars_if.ready && b == 8'h00)) begin
      len_cnt    = '0;
      prn_cnt    = '0;
      alpha_cnt  = '0;
      digit_cnt  = '0;
      space_seen = 1'b0;
      ctl_run    = '0;
      run_rej    = 1'b0;
      len_ovf    = 1'b0;
    end
  end

  always @(posedge clk) begin : check_verdicts
    verdict_t due;
    if (!rst && verdicts_if.valid && verdicts_if.ready) begin
      verdicts_taken <= verdicts_taken + 1;
      if (verdicts_due.size() == 0) begin
        report_mismatch("verdict transaction with no string pending");
      end else begin
        due = verdicts_due.pop_front();
        if (verdicts_if.readable !== due.readable)
          report_mismatch($sformatf("readable %b, expected %b",
                                    verdicts_if.readable, due.readable));
        if (verdicts_if.verdict_code !== due.verdict_code)
          report_mismatch($sformatf("verdict_code %0d, expected %0d",
                                    verdicts_if.verdict_code, due.verdict_code));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (chars_if.valid && chars_if.ready) ||
          (verdicts_if.valid && verdicts_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin
    cfg.min_printable_tenths = RST_MIN_PRINTABLE;
    cfg.min_alpha_tenths     = RST_MIN_ALPHA;
    cfg.max_digit_tenths     = RST_MAX_DIGIT;
    cfg.max_control_run      = RST_MAX_RUN;
    chars_if.valid     = 1'b0;
    chars_if.char_byte = 8'h00;
    verdicts_if.ready  = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // hand-picked strings under reset settings
    push_text("");
    push_text("Hi All");
    push_text("Hi");
    push_text("\001\200\177\377\037a ");
    push_text("Zz 09~ ");
    push_text("\001\001 x");

    run_phase(4'd0, 4'd0, 4'd15, 8'd0, 280);
    run_phase(4'd15, 4'd15, 4'd0, 8'd255, 280);
    // control run past the saturation point, still allowed at the top limit
    repeat (300) chars_pending.push_back(8'h1F);
    push_text("ab c");
    run_phase(4'd10, 4'd10, 4'd10, 8'd1, 280);
    repeat (3) begin
      run_phase(tenths_t'($urandom_range(0, 10)), tenths_t'($urandom_range(0, 6)),
                tenths_t'($urandom_range(2, 15)), run_t'($urandom_range(0, 8)), 280);
    end

    wait_idle();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
